@@ hdl/ipcso_pkg.sv @@
// ----------------------------------------------------------------------------
// ipcso_pkg: shared types, codes and helpers for the checksum offload block
// Status and kind codes, protocol numbers, header offsets, the snapshot of
// one finished packet and the ones-complement adders.
// ----------------------------------------------------------------------------
package ipcso_pkg;

  // Default packet length limit in bytes
  localparam int MAX_PACKET_BYTES_DEF = 65535;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_VERSION = 2'd2;
  localparam logic [1:0] ST_LONG    = 2'd3;

  // Layer 4 kind codes
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TCP  = 2'd1;
  localparam logic [1:0] KIND_UDP  = 2'd2;

  // IP version and protocol numbers
  localparam logic [3:0] IP_V4     = 4'd4;
  localparam logic [3:0] IP_V6     = 4'd6;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Header layout (byte offsets and sizes)
  localparam int OFF_V4_PROTO   = 9;
  localparam int OFF_V6_NEXTHDR = 6;
  localparam int OFF_V4_CSUM    = 10;
  localparam int OFF_V4_SADDR   = 12;
  localparam int OFF_V6_SADDR   = 8;
  localparam int V4_MIN_HDR     = 20;
  localparam int V6_HDR         = 40;
  localparam int TCP_OFF_DOFF   = 12;
  localparam int TCP_OFF_CSUM   = 16;
  localparam int UDP_OFF_CSUM   = 6;
  localparam int UDP_HDR        = 8;

  // Snapshot of one packet taken on its last byte
  typedef struct packed {
    logic [1:0]  err;      // bit 0 bad version, bit 1 overlong
    logic [3:0]  ver;
    logic [5:0]  hdr_bytes;
    logic [7:0]  proto;
    logic [3:0]  tcp_doff;
    logic [15:0] hdr_sum;
    logic [15:0] pseudo_sum;
    logic [15:0] seg_sum;
    logic [15:0] len;
    logic [15:0] l4_len;
  } fin_t;

  // Two-operand ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Three-operand ones-complement add, folded twice
  function automatic logic [15:0] oc_sum3(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    logic [17:0] s;
    logic [16:0] f;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    return f[15:0] + {15'd0, f[16]};
  endfunction

endpackage

@@ hdl/ip_tcp_udp_checksum_offload.sv @@
// ----------------------------------------------------------------------------
// ip_tcp_udp_checksum_offload: streaming IPv4/IPv6 TCP/UDP checksum engine
// Parses the IP header of a byte stream and reports header and L4 checksums.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one packet byte per beat in wire order, in_tlast on the final byte.
//   out_* : one result beat per packet, issued after the final byte.
//           out_tuser = status, IPv4 checksum valid flag and L4 kind;
//           out_tdata = IPv4 header checksum, L4 checksum, L4 checksum offset.
// Path: the last byte's beat passes the input register, the running-sum stage
//   and the result stage, each registered, before the result beat is valid.
// Throughput: one byte per cycle while in_tready is high; packets run back to
//   back with no gap unless a last byte must wait for a free result stage.
// Reset: rst_n (synchronous, active low) empties all stages and restarts the
//   byte counter, so the next byte is taken as byte 0 of a packet.
// Stall: while out_tready is low, a waiting result holds in the output
//   register and one more in the snapshot stage; bytes that are not the last
//   of a packet keep flowing, and in_tready drops only when a last byte finds
//   both result stages full.
// ----------------------------------------------------------------------------
module ip_tcp_udp_checksum_offload #(
  parameter int MAX_PACKET_BYTES = ipcso_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] ip_checksum, [31:16] l4_checksum,
                                  // [47:32] l4_csum_offset
  output logic [4:0]  out_tuser   // [1:0] status, [2] ip_csum_valid, [4:3] l4_kind
);
  import ipcso_pkg::*;

  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic             in_valid_r;
  logic [7:0]       in_data_r;
  logic             in_last_r;
  logic             fin_valid_r;
  fin_t             fin_r;
  logic             out_valid_r;
  logic [47:0]      out_data_r;
  logic [4:0]       out_user_r;

  logic out_free, fin_free, proc, proc_last, in_free;

  assign out_free  = !out_valid_r || out_tready;
  assign fin_free  = !fin_valid_r || out_free;
  assign proc      = in_valid_r && (!in_last_r || fin_free);
  assign proc_last = proc && in_last_r;
  assign in_free   = !in_valid_r || proc;
  assign in_tready = in_free;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_free) begin
      in_valid_r <= in_tvalid;
    end
    if (in_free && in_tvalid) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Running-sum stage: per-packet parse state
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       ver_r, ver_nxt;
  logic [5:0]       hb_r, hb_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [3:0]       doff_r, doff_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [15:0]      hsum_r, hsum_nxt;
  logic [15:0]      psum_r, psum_nxt;
  logic [15:0]      ssum_r, ssum_nxt;
  logic [1:0]       err_r, err_nxt;

  logic             first, okay, is_v4, cap, word_en;
  logic             hdr_hit, ps_hit, seg_hit;
  logic [7:0]       proto_b, held_b;
  logic [3:0]       doff_b;
  logic [15:0]      hsum_b, psum_b, ssum_b, word;
  logic [CNT_W-1:0] hb_x, pos, rel, len_a, l4len_a;

  always_comb begin
    first = (cnt_r == '0);

    // Byte 0 sets version and header length
    ver_nxt = first ? in_data_r[7:4] : ver_r;
    hb_nxt  = hb_r;
    if (first) begin
      if (ver_nxt == IP_V4) begin
        hb_nxt = {in_data_r[3:0], 2'b00};
      end else if (ver_nxt == IP_V6) begin
        hb_nxt = 6'(V6_HDR);
      end else begin
        hb_nxt = 6'd0;
      end
    end
    hb_x = CNT_W'(hb_nxt);

    // Error flags: bad version on byte 0, overlong past the length limit
    err_nxt[0] = first ? !((ver_nxt == IP_V4) || (ver_nxt == IP_V6)) : err_r[0];
    err_nxt[1] = (first ? 1'b0 : err_r[1]) | (cnt_r >= MAX_CNT);
    okay       = (err_nxt == 2'b00);
    is_v4      = (ver_nxt == IP_V4);

    // Restart accumulators on byte 0
    proto_b = first ? 8'd0  : proto_r;
    doff_b  = first ? 4'd0  : doff_r;
    held_b  = first ? 8'd0  : held_r;
    hsum_b  = first ? 16'd0 : hsum_r;
    psum_b  = first ? 16'd0 : psum_r;
    ssum_b  = first ? 16'd0 : ssum_r;

    // Protocol byte
    cap = okay && ((is_v4 && cnt_r == CNT_W'(OFF_V4_PROTO)) ||
                   (ver_nxt == IP_V6 && cnt_r == CNT_W'(OFF_V6_NEXTHDR)));
    proto_nxt = cap ? in_data_r : proto_b;

    // TCP data offset byte
    doff_nxt = doff_b;
    if (okay && proto_nxt == PROTO_TCP && cnt_r >= hb_x &&
        (cnt_r - hb_x) == CNT_W'(TCP_OFF_DOFF)) begin
      doff_nxt = in_data_r[7:4];
    end

    // Hold the high byte of a word
    held_nxt = (okay && !cnt_r[0]) ? in_data_r : held_b;

    // Assemble a word; a trailing odd byte is padded with zero
    pos     = {cnt_r[CNT_W-1:1], 1'b0};
    word    = cnt_r[0] ? {held_b, in_data_r} : {in_data_r, 8'h00};
    word_en = okay && (cnt_r[0] || in_last_r);
    rel     = pos - hb_x;

    hdr_hit = is_v4 && (pos < hb_x) && (pos != CNT_W'(OFF_V4_CSUM));
    ps_hit  = is_v4 ? (pos >= CNT_W'(OFF_V4_SADDR) && pos < CNT_W'(V4_MIN_HDR))
                    : (pos >= CNT_W'(OFF_V6_SADDR) && pos < CNT_W'(V6_HDR));
    seg_hit = (pos >= hb_x) &&
              ((proto_nxt == PROTO_TCP && rel != CNT_W'(TCP_OFF_CSUM)) ||
               (proto_nxt == PROTO_UDP && rel != CNT_W'(UDP_OFF_CSUM)));

    // Accumulate
    hsum_nxt = (word_en && hdr_hit) ? oc_add(hsum_b, word) : hsum_b;
    if (cap) begin
      psum_nxt = oc_add(psum_b, {8'h00, in_data_r});
    end else if (word_en && ps_hit) begin
      psum_nxt = oc_add(psum_b, word);
    end else begin
      psum_nxt = psum_b;
    end
    ssum_nxt = (word_en && seg_hit) ? oc_add(ssum_b, word) : ssum_b;

    // Lengths for the snapshot
    len_a   = cnt_r + CNT_W'(1);
    l4len_a = is_v4 ? (len_a - hb_x) : (len_a - CNT_W'(V6_HDR));

    // Advance the byte counter, saturating at the limit; a last byte clears it
    if (in_last_r) begin
      cnt_nxt = '0;
    end else if (cnt_r < MAX_CNT) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // Update parse state on every processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (proc) begin
      cnt_r <= cnt_nxt;
    end
    if (proc) begin
      ver_r   <= ver_nxt;
      hb_r    <= hb_nxt;
      proto_r <= proto_nxt;
      doff_r  <= doff_nxt;
      held_r  <= held_nxt;
      hsum_r  <= hsum_nxt;
      psum_r  <= psum_nxt;
      ssum_r  <= ssum_nxt;
      err_r   <= err_nxt;
    end
  end

  // Snapshot the packet on its last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_free) begin
      fin_valid_r <= proc_last;
    end
    if (proc_last) begin
      fin_r.err        <= err_nxt;
      fin_r.ver        <= ver_nxt;
      fin_r.hdr_bytes  <= hb_nxt;
      fin_r.proto      <= proto_nxt;
      fin_r.tcp_doff   <= doff_nxt;
      fin_r.hdr_sum    <= hsum_nxt;
      fin_r.pseudo_sum <= psum_nxt;
      fin_r.seg_sum    <= ssum_nxt;
      fin_r.len        <= 16'(len_a);
      fin_r.l4_len     <= 16'(l4len_a);
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: checks and final checksums
  // --------------------------------------------------------------------------
  logic [1:0]  status_c, kind_c;
  logic        ipv_c, good_c;
  logic [15:0] ipc_c, l4c_c, l4off_c, hb16;

  always_comb begin
    status_c = ST_OK;
    kind_c   = KIND_NONE;
    ipv_c    = 1'b0;
    good_c   = 1'b0;
    ipc_c    = 16'd0;
    l4c_c    = 16'd0;
    l4off_c  = 16'd0;
    hb16     = 16'(fin_r.hdr_bytes);

    // IP level checks
    if (fin_r.err[1]) begin
      status_c = ST_LONG;
    end else if (fin_r.err[0]) begin
      status_c = ST_VERSION;
    end else if (fin_r.ver == IP_V4) begin
      if (fin_r.len < 16'(V4_MIN_HDR)) begin
        status_c = ST_SHORT;
      end else if (hb16 < 16'(V4_MIN_HDR)) begin
        status_c = ST_VERSION;
      end else if (fin_r.len <= hb16) begin
        status_c = ST_SHORT;
      end else begin
        ipv_c  = 1'b1;
        ipc_c  = ~fin_r.hdr_sum;
        good_c = 1'b1;
      end
    end else begin
      if (fin_r.len <= 16'(V6_HDR)) begin
        status_c = ST_SHORT;
      end else begin
        good_c = 1'b1;
      end
    end

    // Segment checks and checksum
    if (good_c) begin
      if (fin_r.proto == PROTO_TCP) begin
        if (fin_r.l4_len <= 16'(TCP_OFF_DOFF) ||
            16'({fin_r.tcp_doff, 2'b00}) >= fin_r.l4_len) begin
          status_c = ST_SHORT;
        end else begin
          kind_c  = KIND_TCP;
          l4off_c = hb16 + 16'(TCP_OFF_CSUM);
        end
      end else if (fin_r.proto == PROTO_UDP) begin
        if (fin_r.l4_len <= 16'(UDP_HDR)) begin
          status_c = ST_SHORT;
        end else begin
          kind_c  = KIND_UDP;
          l4off_c = hb16 + 16'(UDP_OFF_CSUM);
        end
      end
      if (kind_c != KIND_NONE) begin
        l4c_c = ~oc_sum3(fin_r.pseudo_sum, fin_r.l4_len, fin_r.seg_sum);
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid_r;
    end
    if (out_free && fin_valid_r) begin
      out_data_r <= {l4off_c, l4c_c, ipc_c};
      out_user_r <= {kind_c, ipv_c, status_c};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An L4 checksum is only reported on a clean packet
  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r[4:3] != KIND_NONE |-> out_user_r[1:0] == ST_OK)
    else $error("L4 kind reported with non-ok status");

  // Version and overlong errors carry no checksums
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_user_r[1:0] == ST_VERSION || out_user_r[1:0] == ST_LONG)
    |-> out_user_r[4:2] == 3'b000 && out_data_r == 48'd0)
    else $error("error result carries checksum fields");

  // The byte counter restarts after a last byte
  a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    proc_last |=> cnt_r == '0)
    else $error("byte counter not cleared after last byte");

  // A blocked snapshot holds its contents
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid_r && !out_free |=> fin_valid_r && $stable(fin_r))
    else $error("snapshot lost while output stalled");

  // No snapshot load without a processed last byte
  a_fin_src: assert property (@(posedge clk) disable iff (!rst_n)
    !fin_valid_r && !proc_last |=> !fin_valid_r)
    else $error("snapshot appeared without a last byte");

endmodule
